FILE: hdl/pressure_correction_coefficients_assert.svh
// Assertion macros for the pressure-correction coefficient RTL, used by the queue.
`ifndef PRESSURE_CORRECTION_COEFFICIENTS_ASSERT_SVH
`define PRESSURE_CORRECTION_COEFFICIENTS_ASSERT_SVH
`ifndef SYNTH
// Property that must hold at every rising clock edge outside reset.
`define PCC_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pcc: property violated");
// Condition that must never be seen outside reset.
`define PCC_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("pcc: forbidden condition seen");
`else
`define PCC_ASSERT(name, clk, rst_n, prop)
`define PCC_NEVER(name, clk, rst_n, cond)
`endif
`endif

FILE: hdl/pcc_pkg.sv
// Shared types and constants of the pressure-correction coefficient block.
package pcc_pkg;

    localparam int IDX_W    = 10;
    localparam int VAL_W    = 32;
    localparam int CFG_W    = 31;
    localparam int GRID_W   = 11;
    localparam int QW       = 46;
    localparam int PW       = 77;
    localparam int COEF_W   = 31;
    localparam int SRC_W    = 32;
    localparam int DIFF_W   = 33;
    localparam int MAG_W    = 32;
    localparam int MU_W     = 63;
    localparam int SUM_W    = 64;
    localparam int DIV_LAT  = 32;
    localparam int SRC_STG  = 5;
    localparam int FIFO_DEPTH = 4;
    localparam int DEF_MAX_GRID = 1024;
    localparam int IN_W     = 280;
    localparam int OUT_W    = 192;
    localparam int NLANE    = 4;

    localparam int LANE_E = 0;
    localparam int LANE_W = 1;
    localparam int LANE_N = 2;
    localparam int LANE_S = 3;

    localparam logic [1:0] SETTLE_CYCLES = 2'd3;

    localparam logic [CFG_W-1:0]  DENSITY_RST = 31'd65536;
    localparam logic [CFG_W-1:0]  SIZE_RST    = 31'd65536;
    localparam logic [GRID_W-1:0] GRID_RST    = 11'd64;
    localparam logic [COEF_W-1:0] COEF_SAT    = {COEF_W{1'b1}};

    // Register map, word index on paddr[3:2].
    typedef enum logic [1:0] {
        REG_DENSITY     = 2'd0,
        REG_CELL_WIDTH  = 2'd1,
        REG_CELL_HEIGHT = 2'd2,
        REG_GRID_CELLS  = 2'd3
    } reg_idx_t;

    // Classified cell handed from the front end to the arithmetic back end.
    typedef struct packed {
        logic [NLANE-1:0]             keep;
        logic [NLANE-1:0][COEF_W-1:0] divisor;
        logic                         fault;
        logic signed [DIFF_W-1:0]     du;
        logic signed [DIFF_W-1:0]     dv;
    } pcc_item_t;

endpackage

FILE: hdl/pcc_front.sv
// Front end: takes input words, finds boundary links and classifies diagonals.
module pcc_front
    import pcc_pkg::*;
#(
    parameter int MAX_GRID = DEF_MAX_GRID
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,
    input  logic [GRID_W-1:0] grid_cells,
    input  logic              cfg_ready,
    input  logic              fifo_full,
    output logic              push,
    output pcc_item_t         item
);

    localparam int NW = $clog2(MAX_GRID + 1);
    localparam int CW = (NW > GRID_W) ? NW : GRID_W;
    localparam int PAY_W = IDX_W * 2 + VAL_W * 8;

    logic              f_valid_reg;
    logic [PAY_W-1:0]  f_data_reg;
    logic              accept;

    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  row;
    logic [VAL_W-1:0]  ap [NLANE];
    logic [VAL_W-1:0]  u_here;
    logic [VAL_W-1:0]  u_west;
    logic [VAL_W-1:0]  v_here;
    logic [VAL_W-1:0]  v_south;
    logic [CW-1:0]     gc_ext;
    logic [CW-1:0]     n_cells;
    logic [CW:0]       col_p1;
    logic [CW:0]       row_p1;
    logic [NLANE-1:0]  used;
    logic [NLANE-1:0]  pos;
    logic signed [DIFF_W-1:0] u_w_ext;
    logic signed [DIFF_W-1:0] u_e_ext;
    logic signed [DIFF_W-1:0] v_s_ext;
    logic signed [DIFF_W-1:0] v_n_ext;

    // Input handshake: one holding register ahead of the queue.
    assign accept   = s_tvalid && s_tready;
    assign push     = f_valid_reg && !fifo_full;
    assign s_tready = cfg_ready && (!f_valid_reg || !fifo_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            f_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            f_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_data_reg <= s_tdata[PAY_W-1:0];
        end
    end

    // Field unpacking.
    assign col      = f_data_reg[9:0];
    assign row      = f_data_reg[19:10];
    assign ap[LANE_E] = f_data_reg[51:20];
    assign ap[LANE_W] = f_data_reg[83:52];
    assign ap[LANE_N] = f_data_reg[115:84];
    assign ap[LANE_S] = f_data_reg[147:116];
    assign u_here   = f_data_reg[179:148];
    assign u_west   = f_data_reg[211:180];
    assign v_here   = f_data_reg[243:212];
    assign v_south  = f_data_reg[275:244];

    // Grid size clamped to the largest supported grid.
    assign gc_ext  = CW'(grid_cells);
    assign n_cells = (gc_ext > CW'(MAX_GRID)) ? CW'(MAX_GRID) : gc_ext;
    assign col_p1  = (CW + 1)'(col) + (CW + 1)'(1);
    assign row_p1  = (CW + 1)'(row) + (CW + 1)'(1);

    // A link exists only where the neighbor cell lies inside the grid.
    assign used[LANE_E] = col_p1 < {1'b0, n_cells};
    assign used[LANE_W] = col != '0;
    assign used[LANE_N] = row_p1 < {1'b0, n_cells};
    assign used[LANE_S] = row != '0;

    // A usable diagonal is strictly positive.
    always_comb
    begin
        for (int i = 0; i < NLANE; i++)
        begin
            pos[i] = !ap[i][VAL_W-1] && (ap[i] != '0);
        end
    end

    for (genvar i = 0; i < NLANE; i++)
    begin : g_divisor
        assign item.divisor[i] = ap[i][COEF_W-1:0];
    end

    assign item.keep  = used & pos;
    assign item.fault = |(used & ~pos);

    // Velocity differences with boundary faces taken as zero.
    assign u_w_ext = used[LANE_W] ? $signed({u_west[VAL_W-1], u_west}) : '0;
    assign u_e_ext = used[LANE_E] ? $signed({u_here[VAL_W-1], u_here}) : '0;
    assign v_s_ext = used[LANE_S] ? $signed({v_south[VAL_W-1], v_south}) : '0;
    assign v_n_ext = used[LANE_N] ? $signed({v_here[VAL_W-1], v_here}) : '0;
    assign item.du = u_w_ext - u_e_ext;
    assign item.dv = v_s_ext - v_n_ext;

endmodule

FILE: hdl/pcc_fifo.sv
// Short queue between the front end and the arithmetic back end.
module pcc_fifo
    import pcc_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  pcc_item_t wr_item,
    input  logic      pop,
    output pcc_item_t rd_item,
    output logic      full,
    output logic      empty
);

    `include "pressure_correction_coefficients_assert.svh"

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pcc_item_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign rd_item = mem[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    `PCC_NEVER(a_fifo_overflow, clk, rst_n, push && full)
    `PCC_NEVER(a_fifo_underflow, clk, rst_n, pop && empty)
    `PCC_ASSERT(a_fifo_fill, clk, rst_n, (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))

endmodule

FILE: hdl/pcc_div.sv
// One coefficient lane: pipelined restoring divider, one quotient bit a stage.
module pcc_div
    import pcc_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [PW-1:0]     numer,
    input  logic [COEF_W-1:0] divisor,
    input  logic              keep,
    output logic [COEF_W-1:0] quo
);

    localparam int HI_W = PW - COEF_W;

    logic [COEF_W-1:0] rem_reg  [0:COEF_W];
    logic [COEF_W-1:0] quo_reg  [0:COEF_W];
    logic [COEF_W-1:0] a_reg    [0:COEF_W-1];
    logic              sat_reg  [0:COEF_W];
    logic              keep_reg [0:COEF_W];
    logic [HI_W-1:0]   hi;

    // Saturation check: the quotient overflows when the upper part reaches the divisor.
    assign hi = numer[PW-1:COEF_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= hi[COEF_W-1:0];
            quo_reg[0]  <= '0;
            a_reg[0]    <= divisor;
            sat_reg[0]  <= hi >= HI_W'(divisor);
            keep_reg[0] <= keep;
        end
    end

    // Long-division steps, most significant remaining numerator bit first.
    for (genvar k = 1; k <= COEF_W; k++)
    begin : g_step
        logic [COEF_W:0] trial;
        logic [COEF_W:0] diff;
        logic            ge;

        assign trial = {rem_reg[k-1], numer[COEF_W-k]};
        assign diff  = trial - {1'b0, a_reg[k-1]};
        assign ge    = trial >= {1'b0, a_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? diff[COEF_W-1:0] : trial[COEF_W-1:0];
                quo_reg[k]  <= {quo_reg[k-1][COEF_W-2:0], ge};
                sat_reg[k]  <= sat_reg[k-1];
                keep_reg[k] <= keep_reg[k-1];
            end
        end

        if (k < COEF_W)
        begin : g_a
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_reg[k] <= a_reg[k-1];
                end
            end
        end
    end

    // Final remainder is not needed; the quotient is masked or saturated.
    assign quo = !keep_reg[COEF_W] ? '0 :
                 (sat_reg[COEF_W] ? COEF_SAT : quo_reg[COEF_W]);

endmodule

FILE: hdl/pcc_back.sv
// Back end: coefficient dividers, source term datapath and output register.
module pcc_back
    import pcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  pcc_item_t          item,
    input  logic               fifo_empty,
    output logic               pop,
    input  logic [QW-1:0]      q_y,
    input  logic [QW-1:0]      q_x,
    input  logic [PW-1:0]      p_y,
    input  logic [PW-1:0]      p_x,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata,
    output logic [0:0]         m_tuser
);

    logic                en;
    logic                s0_valid_reg;
    pcc_item_t           s0_item_reg;
    logic                v_reg   [1:DIV_LAT];
    logic                flt_reg [1:DIV_LAT];
    logic [COEF_W-1:0]   coef    [NLANE];

    // Source datapath stages.
    logic                a_nu_reg, a_nv_reg;
    logic [MAG_W-1:0]    a_mu_reg, a_mv_reg;
    logic [DIFF_W-1:0]   du_abs, dv_abs;
    logic                b_nu_reg, b_nv_reg;
    logic [61:0]         b_uh_reg, b_vh_reg;
    logic [47:0]         b_ul_reg, b_vl_reg;
    logic                c_nu_reg, c_nv_reg;
    logic [MU_W-1:0]     c_mu_reg, c_mv_reg;
    logic                d_neg_reg;
    logic [SUM_W-1:0]    d_mag_reg;
    logic [SUM_W-1:0]    d_mag_next;
    logic                d_neg_next;
    logic [SRC_W-1:0]    e_src_next;
    logic [SRC_W-1:0]    src_reg [SRC_STG:DIV_LAT];

    // Output stage.
    logic                out_valid_reg;
    logic [COEF_W-1:0]   out_coef_reg [NLANE];
    logic [COEF_W-1:0]   out_center_reg;
    logic [SRC_W-1:0]    out_src_reg;
    logic                out_fault_reg;
    logic [COEF_W+1:0]   center_sum;

    // The whole pipeline moves whenever the output register can take a word.
    assign en  = !out_valid_reg || m_tready;
    assign pop = en && !fifo_empty;

    // Pipeline occupancy and fault flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            for (int k = 1; k <= DIV_LAT; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            s0_valid_reg <= !fifo_empty;
            v_reg[1]     <= s0_valid_reg;
            for (int k = 2; k <= DIV_LAT; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_item_reg <= item;
            flt_reg[1]  <= s0_item_reg.fault;
            for (int k = 2; k <= DIV_LAT; k++)
            begin
                flt_reg[k] <= flt_reg[k-1];
            end
        end
    end

    // Four divider lanes: east and west scale with the cell height, north and south with the width.
    for (genvar i = 0; i < NLANE; i++)
    begin : g_lane
        pcc_div u_div (
            .clk     (clk),
            .en      (en),
            .numer   ((i == LANE_E || i == LANE_W) ? p_y : p_x),
            .divisor (s0_item_reg.divisor[i]),
            .keep    (s0_item_reg.keep[i]),
            .quo     (coef[i])
        );
    end

    // Source stage A: magnitudes and signs of the velocity differences.
    assign du_abs = s0_item_reg.du[DIFF_W-1] ? DIFF_W'(-s0_item_reg.du) : s0_item_reg.du;
    assign dv_abs = s0_item_reg.dv[DIFF_W-1] ? DIFF_W'(-s0_item_reg.dv) : s0_item_reg.dv;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_nu_reg <= s0_item_reg.du[DIFF_W-1];
            a_nv_reg <= s0_item_reg.dv[DIFF_W-1];
            a_mu_reg <= du_abs[MAG_W-1:0];
            a_mv_reg <= dv_abs[MAG_W-1:0];
        end
    end

    // Source stage B: split products, high and low parts of the scale.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_nu_reg <= a_nu_reg;
            b_nv_reg <= a_nv_reg;
            b_uh_reg <= q_y[QW-1:16] * a_mu_reg;
            b_ul_reg <= q_y[15:0] * a_mu_reg;
            b_vh_reg <= q_x[QW-1:16] * a_mv_reg;
            b_vl_reg <= q_x[15:0] * a_mv_reg;
        end
    end

    // Source stage C: recombine, dropping the 16 fraction bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_nu_reg <= b_nu_reg;
            c_nv_reg <= b_nv_reg;
            c_mu_reg <= MU_W'(b_uh_reg) + MU_W'(b_ul_reg[47:16]);
            c_mv_reg <= MU_W'(b_vh_reg) + MU_W'(b_vl_reg[47:16]);
        end
    end

    // Source stage D: sign-magnitude sum of the two terms.
    always_comb
    begin
        if (c_nu_reg == c_nv_reg)
        begin
            d_mag_next = SUM_W'(c_mu_reg) + SUM_W'(c_mv_reg);
            d_neg_next = c_nu_reg;
        end
        else if (c_mu_reg >= c_mv_reg)
        begin
            d_mag_next = SUM_W'(c_mu_reg - c_mv_reg);
            d_neg_next = c_nu_reg;
        end
        else
        begin
            d_mag_next = SUM_W'(c_mv_reg - c_mu_reg);
            d_neg_next = c_nv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_mag_reg <= d_mag_next;
            d_neg_reg <= d_neg_next;
        end
    end

    // Source stage E: saturate to the signed 32-bit range, then delay to meet the lanes.
    always_comb
    begin
        if (d_neg_reg)
        begin
            e_src_next = (d_mag_reg >= SUM_W'(64'h8000_0000)) ? 32'h8000_0000
                                                              : (32'd0 - d_mag_reg[SRC_W-1:0]);
        end
        else
        begin
            e_src_next = (d_mag_reg > SUM_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                             : d_mag_reg[SRC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            src_reg[SRC_STG] <= e_src_next;
            for (int k = SRC_STG + 1; k <= DIV_LAT; k++)
            begin
                src_reg[k] <= src_reg[k-1];
            end
        end
    end

    // Center coefficient, saturating.
    assign center_sum = (COEF_W + 2)'(coef[LANE_E]) + (COEF_W + 2)'(coef[LANE_W])
                      + (COEF_W + 2)'(coef[LANE_N]) + (COEF_W + 2)'(coef[LANE_S]);

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v_reg[DIV_LAT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && v_reg[DIV_LAT])
        begin
            for (int i = 0; i < NLANE; i++)
            begin
                out_coef_reg[i] <= coef[i];
            end
            out_center_reg <= (center_sum > (COEF_W + 2)'(COEF_SAT)) ? COEF_SAT
                                                                    : center_sum[COEF_W-1:0];
            out_src_reg    <= src_reg[DIV_LAT];
            out_fault_reg  <= flt_reg[DIV_LAT];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_src_reg, out_center_reg, out_coef_reg[LANE_S],
                       out_coef_reg[LANE_N], out_coef_reg[LANE_W], out_coef_reg[LANE_E]};
    assign m_tuser  = out_fault_reg;

endmodule

FILE: hdl/pressure_correction_coefficients.sv
// Top level of the pressure-correction coefficient block.
//
//   channel   direction  handshake                 payload
//   s_*       in         s_tvalid / s_tready       s_tdata: one cell per word
//   m_*       out        m_tvalid / m_tready       m_tdata coefficients, m_tuser fault
//   apb       in/out     psel, penable, pwrite     paddr, pwdata, prdata
//
// One word is accepted per cycle while s_tready is high; each result passes
// through the holding register, the queue, the back end's entry register, the
// 32-stage divider lanes and the output register. rst_n resets all control
// state; the block then holds s_tready low while the derived scale products
// settle, and again after every register write. A stall on m_tready freezes
// the back end; the four-entry queue keeps the front end taking words until it fills.
module pressure_correction_coefficients
    import pcc_pkg::*;
#(
    parameter int MAX_GRID = DEF_MAX_GRID
)
(
    input  logic               clk,
    input  logic               rst_n,
    // col_index, row_index, ap_u_here, ap_u_west, ap_v_here, ap_v_south,
    // u_here, u_west, v_here, v_south (low bit up), zero padded
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [IN_W-1:0]    s_tdata,
    // east_coef, west_coef, north_coef, south_coef, center_coef, source_term
    // (low bit up), zero padded
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata,
    // divide_fault
    output logic [0:0]         m_tuser,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [CFG_W-1:0]  density_reg;
    logic [CFG_W-1:0]  cell_width_reg;
    logic [CFG_W-1:0]  cell_height_reg;
    logic [GRID_W-1:0] grid_cells_reg;
    logic [1:0]        settle_reg;
    logic              cfg_wr;
    reg_idx_t          reg_idx;

    logic [61:0]       qy_prod, qx_prod;
    logic [QW-1:0]     qy_reg, qx_reg;
    logic [60:0]       pyh_reg, pxh_reg;
    logic [46:0]       pyl_reg, pxl_reg;
    logic [PW-1:0]     py_reg, px_reg;

    logic              push, pop, fifo_full, fifo_empty;
    pcc_item_t         wr_item, rd_item;

    // Register port.
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            density_reg     <= DENSITY_RST;
            cell_width_reg  <= SIZE_RST;
            cell_height_reg <= SIZE_RST;
            grid_cells_reg  <= GRID_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_DENSITY:     density_reg     <= pwdata[CFG_W-1:0];
                REG_CELL_WIDTH:  cell_width_reg  <= pwdata[CFG_W-1:0];
                REG_CELL_HEIGHT: cell_height_reg <= pwdata[CFG_W-1:0];
                REG_GRID_CELLS:  grid_cells_reg  <= pwdata[GRID_W-1:0];
                default:         grid_cells_reg  <= grid_cells_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_DENSITY:     prdata = {1'b0, density_reg};
            REG_CELL_WIDTH:  prdata = {1'b0, cell_width_reg};
            REG_CELL_HEIGHT: prdata = {1'b0, cell_height_reg};
            REG_GRID_CELLS:  prdata = {21'd0, grid_cells_reg};
            default:         prdata = '0;
        endcase
    end

    // Input is held off while the derived products catch up with a write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= SETTLE_CYCLES;
        end
        else if (cfg_wr)
        begin
            settle_reg <= SETTLE_CYCLES;
        end
        else if (settle_reg != 2'd0)
        begin
            settle_reg <= settle_reg - 2'd1;
        end
    end

    // Derived scales: density times cell size, then times cell size again.
    assign qy_prod = density_reg * cell_height_reg;
    assign qx_prod = density_reg * cell_width_reg;

    always_ff @(posedge clk)
    begin
        qy_reg  <= qy_prod[61:16];
        qx_reg  <= qx_prod[61:16];
        pyh_reg <= qy_reg[QW-1:16] * cell_height_reg;
        pyl_reg <= qy_reg[15:0] * cell_height_reg;
        pxh_reg <= qx_reg[QW-1:16] * cell_width_reg;
        pxl_reg <= qx_reg[15:0] * cell_width_reg;
        py_reg  <= {pyh_reg, 16'd0} + PW'(pyl_reg);
        px_reg  <= {pxh_reg, 16'd0} + PW'(pxl_reg);
    end

    pcc_front #(
        .MAX_GRID (MAX_GRID)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .grid_cells (grid_cells_reg),
        .cfg_ready  (settle_reg == 2'd0),
        .fifo_full  (fifo_full),
        .push       (push),
        .item       (wr_item)
    );

    pcc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (wr_item),
        .pop     (pop),
        .rd_item (rd_item),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    pcc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (rd_item),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .q_y        (qy_reg),
        .q_x        (qx_reg),
        .p_y        (py_reg),
        .p_x        (px_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
